### sv/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// shared widths, codes and controller/datapath interface types for the
// stable priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int SEV_W   = 4;
	localparam int PID_W   = 16;
	localparam int STAT_W  = 2;
	localparam int IN_DW   = 24;   // severity, patient id, zero pad
	localparam int OUT_DW  = 24;   // severity, patient id, zero pad

	// request commands
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LIST   = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
	localparam logic [STAT_W-1:0] ST_DROPPED  = 2'd1;
	localparam logic [STAT_W-1:0] ST_LISTED   = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic              do_insert;
		logic              load_out;
		logic [STAT_W-1:0] out_status;
		logic              out_last;
		logic              idx_clear;
		logic              idx_step;
	} spq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic at_last;
		logic out_free;
	} spq_stat_t;

endpackage

### sv/spq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath
// sorted slot row with parallel compare and shift insert, list read
// index and the result register
// ----------------------------------------------------------------------------
module spq_datapath import spq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  spq_cmd_t         cmd,
	output spq_stat_t        stat,
	input  logic [SEV_W-1:0] in_severity,
	input  logic [PID_W-1:0] in_patient_id,
	input  logic             res_ready,
	output logic             res_valid,
	output logic [STAT_W-1:0] res_status,
	output logic [SEV_W-1:0] res_severity,
	output logic [PID_W-1:0] res_patient_id,
	output logic             res_last
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);

	logic [SEV_W-1:0] slot_sev_q [CAPACITY];
	logic [PID_W-1:0] slot_pid_q [CAPACITY];
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic [CAPACITY-1:0] ge;

	logic              valid_q;
	logic [STAT_W-1:0] status_q;
	logic [SEV_W-1:0]  sev_q;
	logic [PID_W-1:0]  pid_q;
	logic              last_q;

	// slots ahead of the new entry: occupied and of equal or higher severity
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			ge[i] = (CNT_W'(i) < count_q) && (slot_sev_q[i] >= in_severity);
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
		always_ff @(posedge clk) begin
			if (cmd.do_insert && !ge[g]) begin
				if (g == 0) begin
					slot_sev_q[g] <= in_severity;
					slot_pid_q[g] <= in_patient_id;
				end else if (ge[(g == 0) ? 0 : g-1]) begin
					slot_sev_q[g] <= in_severity;
					slot_pid_q[g] <= in_patient_id;
				end else begin
					slot_sev_q[g] <= slot_sev_q[(g == 0) ? 0 : g-1];
					slot_pid_q[g] <= slot_pid_q[(g == 0) ? 0 : g-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.do_insert) count_q <= count_q + CNT_W'(1);
			if (cmd.idx_clear) begin
				idx_q <= '0;
			end else if (cmd.idx_step) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.load_out) begin
				valid_q <= 1'b1;
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status_q <= cmd.out_status;
			last_q   <= cmd.out_last;
			if (cmd.out_status == ST_LISTED) begin
				sev_q <= slot_sev_q[idx_q];
				pid_q <= slot_pid_q[idx_q];
			end else begin
				sev_q <= '0;
				pid_q <= '0;
			end
		end
	end

	assign stat.full     = (count_q == CNT_W'(CAPACITY));
	assign stat.empty    = (count_q == '0);
	assign stat.at_last  = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign stat.out_free = !valid_q || res_ready;

	assign res_valid      = valid_q;
	assign res_status     = status_q;
	assign res_severity   = sev_q;
	assign res_patient_id = pid_q;
	assign res_last       = last_q;

endmodule

### sv/spq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// request sequencer: single-result insert and empty list, multi-result list walk
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  logic      req_command,
	input  spq_stat_t stat,
	output spq_cmd_t  cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_LIST = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	assign req_ready = (state_q == S_IDLE) && stat.out_free;
	assign accept    = req_valid && req_ready;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.out_status = ST_INSERTED;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_command == CMD_INSERT) begin
						cmd.do_insert  = !stat.full;
						cmd.load_out   = 1'b1;
						cmd.out_status = stat.full ? ST_DROPPED : ST_INSERTED;
						cmd.out_last   = 1'b1;
					end else if (stat.empty) begin
						cmd.load_out   = 1'b1;
						cmd.out_status = ST_EMPTY;
						cmd.out_last   = 1'b1;
					end else begin
						cmd.idx_clear = 1'b1;
						state_d       = S_LIST;
					end
				end
			end
			S_LIST: begin
				// one listed entry per free slot in the result register
				if (stat.out_free) begin
					cmd.load_out   = 1'b1;
					cmd.out_status = ST_LISTED;
					cmd.out_last   = stat.at_last;
					cmd.idx_step   = 1'b1;
					if (stat.at_last) state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### sv/stable_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// bounded queue sorted by descending severity, stable for equal severity
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  ---------+-----------+-------------------------------------------------
//  s_*      | in        | request: tuser command, tdata severity/patient id
//  m_*      | out       | result: tuser status, tdata entry, tlast final one
//
//  an insert: all slots compare against the new severity in parallel and
//  the row shifts by one behind the insert point
//  a list is accepted, then the stored entries go out in order, each as the
//  result register frees, read through the single slot read port feeding it
//  reset clears the entry count, list index, result valid and the sequencer;
//  slot contents need none; a stalled result holds in the result register;
//  requests wait until it drains or is being taken in the same cycle
// ----------------------------------------------------------------------------
module stable_priority_queue_top import spq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// request stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_DW-1:0]  s_tdata,   // [3:0] severity, [19:4] patient_id, zero pad
	input  logic              s_tuser,   // [0] command
	// result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_DW-1:0] m_tdata,   // [3:0] out_severity, [19:4] out_patient_id, zero pad
	output logic [STAT_W-1:0] m_tuser,   // [1:0] status
	output logic              m_tlast
);

	spq_cmd_t  cmd;
	spq_stat_t stat;

	logic [SEV_W-1:0] res_severity;
	logic [PID_W-1:0] res_patient_id;

	// sequencer: decides per request and walks the queue for a list
	spq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (s_tvalid),
		.req_ready   (s_tready),
		.req_command (s_tuser),
		.stat        (stat),
		.cmd         (cmd)
	);

	// slot row, entry count, list index and result register
	spq_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.in_severity    (s_tdata[SEV_W-1:0]),
		.in_patient_id  (s_tdata[SEV_W+PID_W-1:SEV_W]),
		.res_ready      (m_tready),
		.res_valid      (m_tvalid),
		.res_status     (m_tuser),
		.res_severity   (res_severity),
		.res_patient_id (res_patient_id),
		.res_last       (m_tlast)
	);

	// pack the entry fields, padding bits held at zero
	assign m_tdata = {(OUT_DW-SEV_W-PID_W)'(0), res_patient_id, res_severity};

endmodule
